### design/significand_to_decimal_digits_unit_macros.svh
// Assertion macros for the significand to decimal digits unit.
`ifndef SIGNIFICAND_TO_DECIMAL_DIGITS_UNIT_MACROS_SVH
`define SIGNIFICAND_TO_DECIMAL_DIGITS_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and off while reset is asserted.
`define SDD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, sampled on clk and off while reset is asserted.
`define SDD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SDD_ASSERT_IMPL(label, ante, cons)
`define SDD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### design/sdd_pkg.sv
// Package with the types and constants of the significand to decimal digits unit.
`timescale 1ns / 1ps
package sdd_pkg;

	localparam int FRACTION_WIDTH = 52;
	localparam int EXP_W          = 12;
	localparam int DIGIT_W        = 4;
	localparam int POS_W          = 6;
	// Product of the fraction by ten carries four integer bits on top.
	localparam int PROD_W         = FRACTION_WIDTH + DIGIT_W;

	// Exponent code that marks a subnormal or zero significand.
	localparam logic signed [EXP_W-1:0] SUBNORMAL_EXP = -12'sd1023;

	typedef struct packed {
		logic [FRACTION_WIDTH-1:0] fraction_bits;
		logic signed [EXP_W-1:0]   exponent;
	} in_beat_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [POS_W-1:0]   digit_position;
		logic               last;
	} out_beat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
	} sdd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
	} sdd_status_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} sdd_state_t;

endpackage

### design/significand_to_decimal_digits_unit.sv
// Top level of the significand to decimal digits unit.
//
//  channel  | direction | handshake           | beat
//  ---------+-----------+---------------------+--------------------------------------
//  in       | input     | in_valid / in_stall   | fraction_bits, exponent
//  out      | output    | out_valid / out_stall | digit, digit_position, last
//
// An item yields one beat for the integer digit and one beat for each fraction digit
// up to the lowest set fraction bit, so 1 to 53 beats, one per cycle while out is not
// stalled. The single times-ten adder in the datapath produces one digit a cycle and
// sets that rate. The next item is taken in the cycle the final beat leaves.
// Reset is asynchronous and only clears the controller; there is no clearing pass.
// A stall on out holds the current beat and the fraction register unchanged.
`timescale 1ns / 1ps
`include "significand_to_decimal_digits_unit_macros.svh"
module significand_to_decimal_digits_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sdd_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output sdd_pkg::out_beat_t out_data
);
	import sdd_pkg::*;

	// Commands flow from the controller to the datapath, status flows back.
	sdd_cmd_t    cmd;
	sdd_status_t status;

	// The controller owns both handshakes and decides when the datapath loads a
	// new significand or steps to the next digit.
	sdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath keeps the remaining fraction and the beat now on offer; each
	// step multiplies the fraction by ten and peels off the integer part.
	sdd_datapath u_datapath (
		.clk      (clk),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data),
		.status   (status)
	);

	// A beat that is taken and not final is followed at once by the next digit.
	`SDD_ASSERT_NEXT(a_next_digit, out_valid && !out_stall && !out_data.last, out_valid && out_data.digit_position == $past(out_data.digit_position) + POS_W'(1))
	// An accepted item opens with the integer digit at position zero.
	`SDD_ASSERT_NEXT(a_head_digit, in_valid && !in_stall, out_valid && out_data.digit_position == '0 && out_data.digit <= DIGIT_W'(1))
	// The closing fraction digit is always five.
	`SDD_ASSERT_IMPL(a_final_five, out_valid && out_data.last && out_data.digit_position != '0, out_data.digit == DIGIT_W'(5))
	// No new item is taken while a non-final beat is still on offer.
	`SDD_ASSERT_IMPL(a_no_overlap, out_valid && !out_data.last, in_stall)

endmodule

### design/sdd_datapath.sv
// Datapath: fraction register, times-ten adder and the output beat register.
`timescale 1ns / 1ps
module sdd_datapath (
	input  logic                clk,
	input  sdd_pkg::sdd_cmd_t   cmd,
	input  sdd_pkg::in_beat_t   in_data,
	output sdd_pkg::out_beat_t  out_data,
	output sdd_pkg::sdd_status_t status
);
	import sdd_pkg::*;

	logic [FRACTION_WIDTH-1:0] frac_q;
	out_beat_t                 beat_q;
	logic [PROD_W-1:0]         prod;
	logic [PROD_W-1:0]         frac_ext;

	// Ten times the fraction as eight times plus two times.
	assign frac_ext = {{DIGIT_W{1'b0}}, frac_q};
	assign prod     = (frac_ext << 3) + (frac_ext << 1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			frac_q                <= in_data.fraction_bits;
			beat_q.digit          <= (in_data.exponent != SUBNORMAL_EXP) ?
				DIGIT_W'(1) : DIGIT_W'(0);
			beat_q.digit_position <= '0;
			beat_q.last           <= (in_data.fraction_bits == '0);
		end else if (cmd.step) begin
			frac_q                <= prod[FRACTION_WIDTH-1:0];
			beat_q.digit          <= prod[PROD_W-1:FRACTION_WIDTH];
			beat_q.digit_position <= beat_q.digit_position + POS_W'(1);
			beat_q.last           <= (prod[FRACTION_WIDTH-1:0] == '0);
		end
	end

	assign out_data    = beat_q;
	assign status.last = beat_q.last;

endmodule

### design/sdd_ctrl.sv
// Controller state machine that sequences loading and digit steps.
`timescale 1ns / 1ps
module sdd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  sdd_pkg::sdd_status_t status,
	output sdd_pkg::sdd_cmd_t    cmd
);
	import sdd_pkg::*;

	sdd_state_t state_q;
	sdd_state_t state_next;
	logic       take_out;
	logic       free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		out_valid  = 1'b0;
		take_out   = 1'b0;
		free       = 1'b0;
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				free = 1'b1;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				take_out  = !out_stall;
				// The final beat leaving frees the datapath in the same cycle.
				free      = take_out && status.last;
				cmd.step  = take_out && !status.last;
				if (free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
		cmd.load = in_valid && free;
		if (cmd.load) begin
			state_next = ST_EMIT;
		end
		in_stall = !free;
	end

endmodule

### bench/significand_to_decimal_digits_unit_tb.sv
// Self-checking testbench for the significand to decimal digits unit.
`timescale 1ns / 1ps
module significand_to_decimal_digits_unit_tb;
	import sdd_pkg::*;

	// A random stretch gives way to a quiet one; the hold-off parks the
	// output for long enough that the unit fills and stalls its input.
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_PERCENT  = 18;
	localparam int SETTLE_CYCLES = 80;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;

	// One row of the directed table. When n_typed is zero the row is checked
	// against the predictor; otherwise its one or two digits are written out.
	typedef struct {
		in_beat_t  item;
		int        n_typed;
		out_beat_t t0;
		out_beat_t t1;
	} stim_row_t;

	stim_row_t directed_rows[$];
	out_beat_t digits_due[$];    // digits still owed by the unit, oldest first
	out_beat_t typed_digits[$];  // written-out digits for the item on offer
	out_beat_t no_typed[$];
	int        mismatches = 0;
	bit        quiet = 1'b0;          // no idling on either side while set
	bit        hold_request = 1'b0;   // asks the receiver for one long hold-off

	significand_to_decimal_digits_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Expands one significand into its decimal digits and queues them. The
	// fraction is held left-aligned in 64 bits; times ten pushes the next
	// digit out into the top four bits of a 68-bit product. The expansion is
	// exact, so it stops as soon as the remaining fraction is zero.
	function automatic void predict_digits(input in_beat_t b);
		logic [63:0] frac;
		logic [67:0] prod;
		out_beat_t   beat;
		int unsigned pos;
		frac = {b.fraction_bits, {(64 - FRACTION_WIDTH){1'b0}}};
		beat.digit = (b.exponent == SUBNORMAL_EXP) ? 4'd0 : 4'd1;
		beat.digit_position = '0;
		beat.last = (frac == 64'd0);
		digits_due.push_back(beat);
		pos = 1;
		while (frac != 64'd0 && pos <= FRACTION_WIDTH) begin
			prod = {4'd0, frac} * 68'd10;
			frac = prod[63:0];
			beat.digit = prod[67:64];
			beat.digit_position = POS_W'(pos);
			beat.last = (frac == 64'd0);
			digits_due.push_back(beat);
			pos++;
		end
	endfunction

	function automatic void flag(input string what, input int unsigned want,
			input int unsigned got);
		mismatches++;
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endfunction

	function automatic void add_row(input logic [FRACTION_WIDTH-1:0] frac,
			input logic signed [EXP_W-1:0] exp_code, input int n_typed,
			input out_beat_t t0, input out_beat_t t1);
		stim_row_t r;
		r.item.fraction_bits = frac;
		r.item.exponent = exp_code;
		r.n_typed = n_typed;
		r.t0 = t0;
		r.t1 = t1;
		directed_rows.push_back(r);
	endfunction

	// Random significands lean toward short and mid-length expansions by
	// clearing the low bits, with a share of zero and single-bit fractions.
	// Most exponents lie in the legal range; some are the subnormal marker
	// and some take any 12-bit code.
	function automatic in_beat_t random_item();
		in_beat_t    b;
		logic [63:0] r;
		int          e;
		r = {$urandom, $urandom};
		b.fraction_bits = r[FRACTION_WIDTH-1:0];
		case ($urandom_range(9))
			0: b.fraction_bits = '0;
			1, 2, 3: b.fraction_bits &= {FRACTION_WIDTH{1'b1}} << $urandom_range(FRACTION_WIDTH);
			4: b.fraction_bits = {{(FRACTION_WIDTH - 1){1'b0}}, 1'b1}
				<< $urandom_range(FRACTION_WIDTH - 1);
			default: ;
		endcase
		case ($urandom_range(7))
			0, 1: b.exponent = SUBNORMAL_EXP;
			2: b.exponent = EXP_W'($urandom);
			default: begin
				e = int'($urandom_range(2047)) - 1023;
				b.exponent = e[EXP_W-1:0];
			end
		endcase
		return b;
	endfunction

	// Offers one beat on the input and returns at the edge that takes it.
	// Idle cycles come first, so valid stays high from the first offer until
	// the beat is taken. Handshakes are read at the falling edge, where every
	// signal is settled for the coming rising edge.
	task automatic offer(input in_beat_t b, input out_beat_t typed[$]);
		bit took;
		while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		typed_digits = typed;
		in_data <= b;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			took = in_valid && !in_stall;
			@(posedge clk);
		end while (!took);
	endtask

	// Lowers valid and waits until every owed digit has left the unit.
	task automatic drain();
		in_valid <= 1'b0;
		while (digits_due.size() != 0)
			@(posedge clk);
	endtask

	// Both channels are observed in one place at the falling edge. A beat
	// taken on the input queues its digits before any output beat of the same
	// cycle is checked, so a fast path through the unit cannot race the check.
	always @(negedge clk) begin : watch
		out_beat_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (typed_digits.size() == 0)
					predict_digits(in_data);
				else
					foreach (typed_digits[i])
						digits_due.push_back(typed_digits[i]);
			end
			if (out_valid && !out_stall) begin
				if (digits_due.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected beat, expected none, got %0d/%0d/%0d",
						$time, out_data.digit, out_data.digit_position, out_data.last);
				end else begin
					want = digits_due.pop_front();
					if (out_data.digit !== want.digit)
						flag("digit", want.digit, out_data.digit);
					if (out_data.digit_position !== want.digit_position)
						flag("digit_position", want.digit_position, out_data.digit_position);
					if (out_data.last !== want.last)
						flag("last", want.last, out_data.last);
				end
			end
		end
	end

	// The receiver stalls at random, not at all in the quiet stretch, and
	// once holds the output for a long count of cycles on request.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1)
					@(posedge clk);
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	// The slowest correct run is far below this: about 220 items of at most
	// 53 digits, each digit held up by random stalls, plus the single long
	// hold-off.
	initial begin
		#5_000_000;
		$display("[significand_to_decimal_digits_unit] ERROR");
		$finish;
	end

	initial begin
		out_beat_t typed[$];
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;

		// Zero fractions give only the integer digit, whatever the exponent,
		// including codes outside the legal exponent range.
		add_row('0, 12'sd0, 1, {4'd1, 6'd0, 1'b1}, '0);
		add_row('0, SUBNORMAL_EXP, 1, {4'd0, 6'd0, 1'b1}, '0);
		add_row('0, 12'sd1024, 1, {4'd1, 6'd0, 1'b1}, '0);
		add_row('0, 12'sd2047, 1, {4'd1, 6'd0, 1'b1}, '0);
		add_row('0, 12'h800, 1, {4'd1, 6'd0, 1'b1}, '0);    // most negative code
		add_row('0, -12'sd1022, 1, {4'd1, 6'd0, 1'b1}, '0);
		add_row('0, -12'sd1024, 1, {4'd1, 6'd0, 1'b1}, '0);
		// One half: the integer digit, then a single 5 that ends the item.
		add_row(52'h8000000000000, 12'sd0, 2, {4'd1, 6'd0, 1'b0}, {4'd5, 6'd1, 1'b1});
		add_row(52'h8000000000000, SUBNORMAL_EXP, 2, {4'd0, 6'd0, 1'b0},
			{4'd5, 6'd1, 1'b1});
		// Full-length expansions: the lowest fraction bit is set.
		add_row('1, 12'sd1023, 0, '0, '0);
		add_row('1, SUBNORMAL_EXP, 0, '0, '0);
		add_row(52'h0000000000001, SUBNORMAL_EXP, 0, '0, '0);
		add_row(52'h0000000000001, 12'sd1024, 0, '0, '0);
		add_row(52'h8000000000001, SUBNORMAL_EXP, 0, '0, '0);
		// Short and patterned fractions.
		add_row(52'h4000000000000, 12'sd1, 0, '0, '0);
		add_row(52'hC000000000000, -12'sd1, 0, '0, '0);
		add_row(52'h5555555555555, -12'sd1, 0, '0, '0);
		add_row(52'hAAAAAAAAAAAAA, 12'sd1, 0, '0, '0);
		add_row(52'h0000000000002, 12'sd2047, 0, '0, '0);
		add_row(52'h0123456789ABC, 12'sd0, 0, '0, '0);
		add_row(52'hFFFFFFFFFFFFE, 12'h800, 0, '0, '0);

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			typed.delete();
			if (directed_rows[i].n_typed >= 1)
				typed.push_back(directed_rows[i].t0);
			if (directed_rows[i].n_typed >= 2)
				typed.push_back(directed_rows[i].t1);
			offer(directed_rows[i].item, typed);
		end

		// The sender pauses until the unit has nothing left to emit.
		drain();

		repeat (70)
			offer(random_item(), no_typed);

		// The receiver parks the output; the sender keeps offering, so the
		// unit fills and holds its input stalled for most of the hold-off.
		hold_request = 1'b1;
		repeat (10)
			offer(random_item(), no_typed);

		quiet = 1'b1;
		repeat (50)
			offer(random_item(), no_typed);
		quiet = 1'b0;

		repeat (70)
			offer(random_item(), no_typed);

		drain();
		// Waiting on afterwards catches any stray beat after the last owed digit.
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		if (mismatches == 0)
			$display("[significand_to_decimal_digits_unit] OK");
		else
			$display("[significand_to_decimal_digits_unit] ERROR");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/sdd_pkg.sv
design/sdd_datapath.sv
design/sdd_ctrl.sv
design/significand_to_decimal_digits_unit.sv
bench/significand_to_decimal_digits_unit_tb.sv
